>>> src/sfcs_pkg.sv
`timescale 1ns / 1ps

package sfcs_pkg;

  localparam int unsigned SECTOR_BYTES      = 512;
  localparam int unsigned CHUNK_BYTES       = 64;
  localparam int unsigned ERASE_BLOCK_BYTES = 4096;

  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned UNITS_W = 19;
  localparam int unsigned PADDR_W = 3;

  localparam logic [UNITS_W-1:0] UNITS_MAX = '1;

  localparam logic [7:0] CMD_WREN    = 8'h06;
  localparam logic [7:0] CMD_ERASE4K = 8'h20;
  localparam logic [7:0] CMD_PROGRAM = 8'h02;
  localparam logic [7:0] CMD_READ    = 8'h03;
  localparam logic [7:0] CMD_RDSR    = 8'h05;
  localparam logic [7:0] CMD_WRSR    = 8'h01;

  localparam int unsigned STATUS_BUSY_BIT = 0;
  localparam int unsigned STATUS_ERR_BIT  = 5;

  localparam logic [PADDR_W-1:0] ADDR_LOG_START = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_LOG_END   = 3'd4;

  typedef enum logic [2:0] {
    OP_ERASE     = 3'd0,
    OP_WRITE     = 3'd1,
    OP_READ      = 3'd2,
    OP_LOG       = 3'd3,
    OP_STATUS    = 3'd4,
    OP_BUS       = 3'd5,
    OP_UNPROTECT = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ACT_WREN    = 3'd0,
    ACT_ERASE4K = 3'd1,
    ACT_PROGRAM = 3'd2,
    ACT_READ    = 3'd3,
    ACT_RDSR    = 3'd4,
    ACT_FETCH   = 3'd5,
    ACT_DELIVER = 3'd6,
    ACT_DONE    = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    RC_OK  = 2'd0,
    RC_HW  = 2'd1,
    RC_BUS = 2'd2
  } rc_e;

  typedef enum logic [5:0] {
    MODE_IDLE     = 6'b000001,
    MODE_ERASE    = 6'b000010,
    MODE_WRITE    = 6'b000100,
    MODE_READ     = 6'b001000,
    MODE_LOGERASE = 6'b010000,
    MODE_LOGPROG  = 6'b100000
  } mode_e;

  typedef enum logic [3:0] {
    PH_NONE  = 4'b0001,
    PH_POLL  = 4'b0010,
    PH_CHECK = 4'b0100,
    PH_BUS   = 4'b1000
  } phase_e;

  typedef struct packed {
    op_e         opcode;
    logic [14:0] sector_lba;
    logic [15:0] sector_count;
    logic [7:0]  record_length;
    logic [7:0]  flash_status;
    logic        bus_ok;
  } in_item_t;

  typedef struct packed {
    action_e           action;
    logic [7:0]        flash_command;
    logic [ADDR_W-1:0] flash_address;
    logic [7:0]        transfer_length;
    rc_e               result_code;
  } res_item_t;

  typedef struct packed {
    logic [1:0]         count;
    res_item_t [2:0]    items;
  } bundle_t;

  typedef struct packed {
    mode_e              mode;
    phase_e             phase;
    logic [ADDR_W-1:0]  work_address;
    logic [UNITS_W-1:0] units_left;
    logic [ADDR_W-1:0]  log_address;
  } seq_state_t;

endpackage

>>> src/sfcs_cfg.sv
`timescale 1ns / 1ps

module sfcs_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfcs_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [sfcs_pkg::ADDR_W-1:0]    log_start_o,
  output logic [sfcs_pkg::ADDR_W-1:0]    log_end_o
);

  logic [sfcs_pkg::ADDR_W-1:0] log_start_q;
  logic [sfcs_pkg::ADDR_W-1:0] log_end_q;
  logic                        wr_en;
  logic                        sel_end;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign sel_end = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_start_q <= '0;
      log_end_q   <= '1;
    end else if (wr_en) begin
      if (sel_end) begin
        log_end_q <= pwdata[sfcs_pkg::ADDR_W-1:0];
      end else begin
        log_start_q <= pwdata[sfcs_pkg::ADDR_W-1:0];
      end
    end
  end

  always_comb begin
    if (sel_end) begin
      prdata = {8'd0, log_end_q};
    end else begin
      prdata = {8'd0, log_start_q};
    end
  end

  assign log_start_o = log_start_q;
  assign log_end_o   = log_end_q;

endmodule

>>> src/sfcs_step.sv
`timescale 1ns / 1ps

module sfcs_step (
  input  sfcs_pkg::in_item_t             item_i,
  input  sfcs_pkg::seq_state_t           state_i,
  input  logic [sfcs_pkg::ADDR_W-1:0]    log_start_i,
  input  logic [sfcs_pkg::ADDR_W-1:0]    log_end_i,
  output sfcs_pkg::seq_state_t           state_o,
  output sfcs_pkg::bundle_t              bundle_o
);

  localparam logic [sfcs_pkg::ADDR_W-1:0] SECTOR_STRIDE = 24'(sfcs_pkg::SECTOR_BYTES);
  localparam logic [sfcs_pkg::ADDR_W-1:0] CHUNK_STRIDE  = 24'(sfcs_pkg::CHUNK_BYTES);
  localparam logic [7:0]                  CHUNK_LEN     = 8'(sfcs_pkg::CHUNK_BYTES);
  localparam logic [sfcs_pkg::ADDR_W-1:0] BLOCK_MASK    =
    24'(sfcs_pkg::ERASE_BLOCK_BYTES - 1);
  localparam int unsigned UNITS_PER_SECTOR =
    sfcs_pkg::SECTOR_BYTES / sfcs_pkg::CHUNK_BYTES;

  function automatic sfcs_pkg::res_item_t mk(sfcs_pkg::action_e act, logic [7:0] cmd,
                                             logic [23:0] addr, logic [7:0] len,
                                             sfcs_pkg::rc_e rc);
    sfcs_pkg::res_item_t it;
    it.action          = act;
    it.flash_command   = cmd;
    it.flash_address   = addr;
    it.transfer_length = len;
    it.result_code     = rc;
    return it;
  endfunction

  function automatic sfcs_pkg::bundle_t done_items(sfcs_pkg::rc_e rc);
    sfcs_pkg::bundle_t b;
    b          = '0;
    b.count    = 2'd1;
    b.items[0] = mk(sfcs_pkg::ACT_DONE, 8'd0, '0, 8'd0, rc);
    return b;
  endfunction

  function automatic sfcs_pkg::bundle_t erase_items(logic [23:0] addr);
    sfcs_pkg::bundle_t b;
    b.count    = 2'd3;
    b.items[0] = mk(sfcs_pkg::ACT_WREN, sfcs_pkg::CMD_WREN, '0, 8'd0, sfcs_pkg::RC_OK);
    b.items[1] = mk(sfcs_pkg::ACT_ERASE4K, sfcs_pkg::CMD_ERASE4K, addr, 8'd0,
                    sfcs_pkg::RC_OK);
    b.items[2] = mk(sfcs_pkg::ACT_RDSR, sfcs_pkg::CMD_RDSR, '0, 8'd0, sfcs_pkg::RC_OK);
    return b;
  endfunction

  function automatic sfcs_pkg::bundle_t prog_items(logic [23:0] addr, logic [7:0] len);
    sfcs_pkg::bundle_t b;
    b.count    = 2'd3;
    b.items[0] = mk(sfcs_pkg::ACT_WREN, sfcs_pkg::CMD_WREN, '0, 8'd0, sfcs_pkg::RC_OK);
    b.items[1] = mk(sfcs_pkg::ACT_PROGRAM, sfcs_pkg::CMD_PROGRAM, addr, len,
                    sfcs_pkg::RC_OK);
    b.items[2] = mk(sfcs_pkg::ACT_RDSR, sfcs_pkg::CMD_RDSR, '0, 8'd0, sfcs_pkg::RC_OK);
    return b;
  endfunction

  function automatic sfcs_pkg::bundle_t unit_items(sfcs_pkg::mode_e mode,
                                                   logic [23:0] addr);
    sfcs_pkg::bundle_t b;
    b = '0;
    if (mode == sfcs_pkg::MODE_ERASE) begin
      b = erase_items(addr);
    end else if (mode == sfcs_pkg::MODE_WRITE) begin
      b.count    = 2'd2;
      b.items[0] = mk(sfcs_pkg::ACT_WREN, sfcs_pkg::CMD_WREN, '0, 8'd0, sfcs_pkg::RC_OK);
      b.items[1] = mk(sfcs_pkg::ACT_FETCH, 8'd0, '0, 8'd0, sfcs_pkg::RC_OK);
    end else begin
      b.count    = 2'd2;
      b.items[0] = mk(sfcs_pkg::ACT_READ, sfcs_pkg::CMD_READ, addr, CHUNK_LEN,
                      sfcs_pkg::RC_OK);
      b.items[1] = mk(sfcs_pkg::ACT_DELIVER, 8'd0, '0, 8'd0, sfcs_pkg::RC_OK);
    end
    return b;
  endfunction

  logic [sfcs_pkg::ADDR_W-1:0]  base;
  logic [31:0]                  units_raw;
  logic [sfcs_pkg::UNITS_W-1:0] units_sat;
  logic                         idle;
  logic [sfcs_pkg::ADDR_W:0]    log_sum;
  logic [sfcs_pkg::ADDR_W:0]    log_lim;
  logic [sfcs_pkg::ADDR_W-1:0]  log_wrap;
  logic [sfcs_pkg::ADDR_W-1:0]  stride;
  logic [sfcs_pkg::ADDR_W-1:0]  next_addr;
  logic [sfcs_pkg::UNITS_W-1:0] next_units;
  sfcs_pkg::phase_e             unit_phase;

  assign base      = 24'(32'(item_i.sector_lba) * sfcs_pkg::SECTOR_BYTES);
  assign units_raw = 32'(item_i.sector_count) * UNITS_PER_SECTOR;
  assign units_sat = (units_raw > 32'(sfcs_pkg::UNITS_MAX)) ? sfcs_pkg::UNITS_MAX
                                                            : units_raw[18:0];
  assign idle      = (state_i.mode == sfcs_pkg::MODE_IDLE);
  assign log_sum   = {1'b0, state_i.log_address} + 25'(item_i.record_length);
  assign log_lim   = {1'b0, log_end_i} + 25'd1;
  assign log_wrap  = (log_sum > log_lim) ? log_start_i : state_i.log_address;

  assign stride     = (state_i.mode == sfcs_pkg::MODE_ERASE) ? SECTOR_STRIDE : CHUNK_STRIDE;
  assign next_addr  = state_i.work_address + stride;
  assign next_units = state_i.units_left - 19'd1;
  assign unit_phase = (state_i.mode == sfcs_pkg::MODE_ERASE) ? sfcs_pkg::PH_POLL
                                                             : sfcs_pkg::PH_BUS;

  always_comb begin
    logic do_next;
    do_next  = 1'b0;
    state_o  = state_i;
    bundle_o = '0;

    case (item_i.opcode)
      sfcs_pkg::OP_ERASE: begin
        if (idle) begin
          state_o.mode         = sfcs_pkg::MODE_ERASE;
          state_o.units_left   = 19'(item_i.sector_count);
          state_o.work_address = base;
          if (item_i.sector_count == '0) begin
            bundle_o      = done_items(sfcs_pkg::RC_OK);
            state_o.mode  = sfcs_pkg::MODE_IDLE;
            state_o.phase = sfcs_pkg::PH_NONE;
          end else begin
            bundle_o      = erase_items(base);
            state_o.phase = sfcs_pkg::PH_POLL;
          end
        end
      end
      sfcs_pkg::OP_WRITE, sfcs_pkg::OP_READ: begin
        if (idle) begin
          state_o.mode = (item_i.opcode == sfcs_pkg::OP_WRITE) ? sfcs_pkg::MODE_WRITE
                                                               : sfcs_pkg::MODE_READ;
          state_o.units_left   = units_sat;
          state_o.work_address = base;
          if (units_sat == '0) begin
            bundle_o      = done_items(sfcs_pkg::RC_OK);
            state_o.mode  = sfcs_pkg::MODE_IDLE;
            state_o.phase = sfcs_pkg::PH_NONE;
          end else begin
            bundle_o      = unit_items(state_o.mode, base);
            state_o.phase = sfcs_pkg::PH_BUS;
          end
        end
      end
      sfcs_pkg::OP_LOG: begin
        if (idle) begin
          state_o.units_left = 19'(item_i.record_length);
          state_o.phase      = sfcs_pkg::PH_POLL;
          if ((log_wrap & BLOCK_MASK) == '0) begin
            state_o.mode        = sfcs_pkg::MODE_LOGERASE;
            state_o.log_address = log_wrap;
            bundle_o            = erase_items(log_wrap);
          end else begin
            state_o.mode        = sfcs_pkg::MODE_LOGPROG;
            state_o.log_address = log_wrap + 24'(item_i.record_length);
            bundle_o            = prog_items(log_wrap, item_i.record_length);
          end
        end
      end
      sfcs_pkg::OP_UNPROTECT: begin
        if (idle) begin
          bundle_o.count    = 2'd3;
          bundle_o.items[0] = mk(sfcs_pkg::ACT_WREN, sfcs_pkg::CMD_WREN, '0, 8'd0,
                                 sfcs_pkg::RC_OK);
          bundle_o.items[1] = mk(sfcs_pkg::ACT_PROGRAM, sfcs_pkg::CMD_WRSR, '0, 8'd1,
                                 sfcs_pkg::RC_OK);
          bundle_o.items[2] = mk(sfcs_pkg::ACT_DONE, 8'd0, '0, 8'd0, sfcs_pkg::RC_OK);
          state_o.log_address = log_start_i;
          state_o.mode        = sfcs_pkg::MODE_IDLE;
          state_o.phase       = sfcs_pkg::PH_NONE;
        end
      end
      sfcs_pkg::OP_STATUS: begin
        if (!idle && state_i.phase == sfcs_pkg::PH_POLL) begin
          bundle_o.count    = 2'd1;
          bundle_o.items[0] = mk(sfcs_pkg::ACT_RDSR, sfcs_pkg::CMD_RDSR, '0, 8'd0,
                                 sfcs_pkg::RC_OK);
          if (!item_i.flash_status[sfcs_pkg::STATUS_BUSY_BIT]) begin
            state_o.phase = sfcs_pkg::PH_CHECK;
          end
        end else if (!idle && state_i.phase == sfcs_pkg::PH_CHECK) begin
          if (item_i.flash_status[sfcs_pkg::STATUS_ERR_BIT]) begin
            bundle_o      = done_items(sfcs_pkg::RC_HW);
            state_o.mode  = sfcs_pkg::MODE_IDLE;
            state_o.phase = sfcs_pkg::PH_NONE;
          end else begin
            unique case (state_i.mode)
              sfcs_pkg::MODE_ERASE, sfcs_pkg::MODE_WRITE: begin
                do_next = 1'b1;
              end
              sfcs_pkg::MODE_LOGERASE: begin
                bundle_o            = prog_items(state_i.log_address,
                                                 state_i.units_left[7:0]);
                state_o.log_address = state_i.log_address + 24'(state_i.units_left[7:0]);
                state_o.mode        = sfcs_pkg::MODE_LOGPROG;
                state_o.phase       = sfcs_pkg::PH_POLL;
              end
              default: begin
                bundle_o      = done_items(sfcs_pkg::RC_OK);
                state_o.mode  = sfcs_pkg::MODE_IDLE;
                state_o.phase = sfcs_pkg::PH_NONE;
              end
            endcase
          end
        end
      end
      sfcs_pkg::OP_BUS: begin
        if (!idle && state_i.phase == sfcs_pkg::PH_BUS) begin
          if (!item_i.bus_ok) begin
            bundle_o      = done_items(sfcs_pkg::RC_BUS);
            state_o.mode  = sfcs_pkg::MODE_IDLE;
            state_o.phase = sfcs_pkg::PH_NONE;
          end else if (state_i.mode == sfcs_pkg::MODE_WRITE) begin
            bundle_o.count    = 2'd2;
            bundle_o.items[0] = mk(sfcs_pkg::ACT_PROGRAM, sfcs_pkg::CMD_PROGRAM,
                                   state_i.work_address, CHUNK_LEN, sfcs_pkg::RC_OK);
            bundle_o.items[1] = mk(sfcs_pkg::ACT_RDSR, sfcs_pkg::CMD_RDSR, '0, 8'd0,
                                   sfcs_pkg::RC_OK);
            state_o.phase     = sfcs_pkg::PH_POLL;
          end else begin
            do_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_next) begin
      state_o.work_address = next_addr;
      state_o.units_left   = next_units;
      if (next_units == '0) begin
        bundle_o      = done_items(sfcs_pkg::RC_OK);
        state_o.mode  = sfcs_pkg::MODE_IDLE;
        state_o.phase = sfcs_pkg::PH_NONE;
      end else begin
        bundle_o      = unit_items(state_i.mode, next_addr);
        state_o.phase = unit_phase;
      end
    end
  end

endmodule

>>> src/sfcs_out.sv
`timescale 1ns / 1ps

module sfcs_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  sfcs_pkg::bundle_t   bundle_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sfcs_pkg::res_item_t item_o,
  output logic                last_o
);

  logic [1:0]        cnt_q;
  logic [1:0]        idx_q;
  sfcs_pkg::bundle_t bundle_q;
  logic              pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o & out_ready_i;
  assign ready_o     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= bundle_i.count;
      idx_q <= 2'd0;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

  assign item_o = bundle_q.items[idx_q];
  assign last_o = (cnt_q == 2'd1);

endmodule

>>> src/spi_flash_command_sequencer.sv
`timescale 1ns / 1ps
// Data path: an accepted input item is registered in item_q, then its result items are
// registered in the output serializer, which presents the first. Throughput: one input
// item per cycle when it causes at most one result item and out_ready_i is not held low;
// otherwise the next input item waits until the output serializer hands out the last one.
// Reset (rst_ni low, asynchronous): sequencer idle, log address 0, registers at defaults.

module spi_flash_command_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfcs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   opcode_i,
  input  logic [14:0]                  sector_lba_i,
  input  logic [15:0]                  sector_count_i,
  input  logic [7:0]                   record_length_i,
  input  logic [7:0]                   flash_status_i,
  input  logic                         bus_ok_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   action_o,
  output logic [7:0]                   flash_command_o,
  output logic [23:0]                  flash_address_o,
  output logic [7:0]                   transfer_length_o,
  output logic [1:0]                   result_code_o,
  output logic                         last_o
);

  logic [sfcs_pkg::ADDR_W-1:0] log_start;
  logic [sfcs_pkg::ADDR_W-1:0] log_end;
  sfcs_pkg::in_item_t          item_q;
  logic                        item_vld_q;
  sfcs_pkg::seq_state_t        state_q;
  sfcs_pkg::seq_state_t        state_d;
  sfcs_pkg::bundle_t           bundle;
  sfcs_pkg::res_item_t         res_item;
  logic                        ser_ready;
  logic                        fire;
  logic                        load;
  logic                        in_acc;

  sfcs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .log_start_o (log_start),
    .log_end_o   (log_end)
  );

  assign fire       = item_vld_q & ((bundle.count == 2'd0) | ser_ready);
  assign load       = fire & (bundle.count != 2'd0);
  assign in_ready_o = ~item_vld_q | fire;
  assign in_acc     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_acc) begin
      item_vld_q <= 1'b1;
    end else if (fire) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.opcode        <= sfcs_pkg::op_e'(opcode_i);
      item_q.sector_lba    <= sector_lba_i;
      item_q.sector_count  <= sector_count_i;
      item_q.record_length <= record_length_i;
      item_q.flash_status  <= flash_status_i;
      item_q.bus_ok        <= bus_ok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode         <= sfcs_pkg::MODE_IDLE;
      state_q.phase        <= sfcs_pkg::PH_NONE;
      state_q.work_address <= '0;
      state_q.units_left   <= '0;
      state_q.log_address  <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  sfcs_step u_step (
    .item_i      (item_q),
    .state_i     (state_q),
    .log_start_i (log_start),
    .log_end_i   (log_end),
    .state_o     (state_d),
    .bundle_o    (bundle)
  );

  sfcs_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .ready_o     (ser_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .item_o      (res_item),
    .last_o      (last_o)
  );

  assign action_o          = res_item.action;
  assign flash_command_o   = res_item.flash_command;
  assign flash_address_o   = res_item.flash_address;
  assign transfer_length_o = res_item.transfer_length;
  assign result_code_o     = res_item.result_code;

endmodule
